// ----- sv/lenient_utf8_decoder_macros.svh -----
// Assertion macros shared by the lenient UTF-8 decoder modules.
`ifndef LENIENT_UTF8_DECODER_MACROS_SVH
`define LENIENT_UTF8_DECODER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define U8D_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8d same-cycle check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define U8D_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8d next-cycle check failed");

`endif

// ----- sv/u8d_pkg.sv -----
// Types, constants and the single-byte mapping for the lenient UTF-8 decoder.
package u8d_pkg;

    localparam int BYTE_W  = 8;
    localparam int CP_W    = 21;
    localparam int MAX_RES = 4;
    localparam int CNT_W   = $clog2(MAX_RES + 1);
    localparam int RES_IW  = $clog2(MAX_RES);
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    typedef logic [BYTE_W-1:0] t_byte;
    typedef logic [CP_W-1:0]   t_cp;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [1:0]        t_need;

    // One beat of input carries a data byte or an end-of-stream mark.
    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_EOS  = 1'b1;

    // Byte class boundaries.
    localparam t_byte CONT_LO   = 8'h80;
    localparam t_byte WIN_HI    = 8'hA0;
    localparam t_byte LEAD2_LO  = 8'hC0;
    localparam t_byte LEAD3_LO  = 8'hE0;
    localparam t_byte LEAD4_LO  = 8'hF0;
    localparam t_byte LATIN_LO  = 8'hF8;

    // All results caused by one input beat.
    typedef struct packed {
        t_cnt                  cnt;
        logic [MAX_RES-1:0][CP_W-1:0] cp;
    } t_job;

    // Windows-1252 code points for bytes 0x80 to 0x9F.
    localparam logic [31:0][15:0] CP1252_LOW = {
        16'h0178, 16'h017E, 16'h009D, 16'h0153, 16'h203A, 16'h0161, 16'h2122, 16'h02DC,
        16'h2014, 16'h2013, 16'h2022, 16'h201D, 16'h201C, 16'h2019, 16'h2018, 16'h0090,
        16'h008F, 16'h017D, 16'h008D, 16'h0152, 16'h2039, 16'h0160, 16'h2030, 16'h02C6,
        16'h2021, 16'h2020, 16'h2026, 16'h201E, 16'h0192, 16'h201A, 16'h0081, 16'h20AC
    };

    // A byte shown on its own: Windows-1252 in 0x80..0x9F, Latin-1 elsewhere.
    function automatic t_cp single_byte(input t_byte b);
        t_cp v;
        if (b >= CONT_LO && b < WIN_HI) begin
            v = t_cp'(CP1252_LOW[b[4:0]]);
        end else begin
            v = t_cp'(b);
        end
        return v;
    endfunction

endpackage

// ----- sv/u8d_if.sv -----
// Valid/ready channel interfaces for the decoder input and output beats.
interface u8d_in_if;
    logic             valid;
    logic             ready;
    logic             mode;
    u8d_pkg::t_byte   data_byte;

    modport source (output valid, output mode, output data_byte, input ready);
    modport sink   (input valid, input mode, input data_byte, output ready);
endinterface

interface u8d_out_if;
    logic             valid;
    logic             ready;
    u8d_pkg::t_cp     code_point;
    logic             last_of_run;

    modport source (output valid, output code_point, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input last_of_run, output ready);
endinterface

// ----- sv/u8d_front.sv -----
// Front end: accepts bytes, tracks the pending sequence and builds result jobs.
`include "lenient_utf8_decoder_macros.svh"

module u8d_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    u8d_in_if.sink        i_in,
    input  logic          i_q_full,
    output logic          o_push,
    output u8d_pkg::t_job o_job
);
    import u8d_pkg::*;

    logic               r_active;
    t_byte              r_lead;
    t_need              r_need;
    t_need              r_held_cnt;
    t_byte [1:0]        r_held;

    logic               n_active;
    t_byte              n_lead;
    t_need              n_need;
    t_need              n_held_cnt;
    t_byte [1:0]        n_held;

    t_job               job;
    logic               fresh;
    logic               accept;
    logic               is_cont;
    logic               is_lead;
    t_byte              b;

    assign b       = i_in.data_byte;
    assign accept  = i_in.valid && i_in.ready;
    assign is_cont = (b >= CONT_LO) && (b < LEAD2_LO);
    assign is_lead = (b >= LEAD2_LO) && (b < LATIN_LO);

    // Classify the beat and collect the results it causes.
    always_comb begin
        n_active   = r_active;
        n_lead     = r_lead;
        n_need     = r_need;
        n_held_cnt = r_held_cnt;
        n_held     = r_held;
        job        = '0;
        fresh      = 1'b0;

        if (i_in.mode == MODE_EOS) begin
            if (r_active) begin
                job.cnt   = t_cnt'(r_held_cnt) + t_cnt'(1);
                job.cp[0] = t_cp'(r_lead);
                job.cp[1] = single_byte(r_held[0]);
                job.cp[2] = single_byte(r_held[1]);
                n_active   = 1'b0;
                n_lead     = '0;
                n_need     = '0;
                n_held_cnt = '0;
            end
        end else if (r_active && is_cont && (r_held_cnt < r_need)) begin
            if (t_need'(r_held_cnt + 2'd1) == r_need) begin
                // Sequence complete: assemble with the current byte as the last one.
                job.cnt = t_cnt'(1);
                case (r_need)
                    2'd1: job.cp[0] = {10'b0, r_lead[4:0], b[5:0]};
                    2'd2: job.cp[0] = {5'b0, r_lead[3:0], r_held[0][5:0], b[5:0]};
                    default: job.cp[0] = {r_lead[2:0], r_held[0][5:0], r_held[1][5:0],
                                          b[5:0]};
                endcase
                n_active   = 1'b0;
                n_lead     = '0;
                n_need     = '0;
                n_held_cnt = '0;
            end else begin
                n_held[r_held_cnt[0]] = b;
                n_held_cnt            = t_need'(r_held_cnt + 2'd1);
            end
        end else begin
            // No sequence pending, or a broken one: replay its start byte and held bytes first.
            if (r_active) begin
                job.cnt   = t_cnt'(r_held_cnt) + t_cnt'(1);
                job.cp[0] = t_cp'(r_lead);
                job.cp[1] = single_byte(r_held[0]);
                job.cp[2] = single_byte(r_held[1]);
                n_active   = 1'b0;
                n_lead     = '0;
                n_need     = '0;
                n_held_cnt = '0;
            end
            fresh = 1'b1;
        end

        // Handle the new byte as if nothing were pending.
        if (fresh) begin
            if (is_lead) begin
                n_active   = 1'b1;
                n_lead     = b;
                n_need     = (b < LEAD3_LO) ? 2'd1 : (b < LEAD4_LO) ? 2'd2 : 2'd3;
                n_held_cnt = '0;
            end else begin
                job.cp[job.cnt[RES_IW-1:0]] = single_byte(b);
                job.cnt                     = job.cnt + t_cnt'(1);
            end
        end
    end

    assign i_in.ready = !i_q_full;
    assign o_push     = accept && (job.cnt != '0);
    assign o_job      = job;

    // Sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_lead     <= '0;
            r_need     <= '0;
            r_held_cnt <= '0;
        end else if (accept) begin
            r_active   <= n_active;
            r_lead     <= n_lead;
            r_need     <= n_need;
            r_held_cnt <= n_held_cnt;
        end
    end

    // Held continuation bytes carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_held <= n_held;
        end
    end

    `U8D_ASSERT_IMP(a_held_below_need, i_clk, i_rst_n, r_active, r_held_cnt < r_need)
    `U8D_ASSERT_IMP(a_idle_clean, i_clk, i_rst_n, !r_active, r_held_cnt == 2'd0 && r_need == 2'd0)

endmodule

// ----- sv/u8d_queue.sv -----
// Job queue between the front end and the result serializer.
`include "lenient_utf8_decoder_macros.svh"

module u8d_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  u8d_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_head_valid,
    output u8d_pkg::t_job o_head
);
    import u8d_pkg::*;

    t_job               r_mem [Q_DEPTH];
    logic [Q_AW-1:0]    r_wr;
    logic [Q_AW-1:0]    r_rd;
    logic [Q_AW:0]      r_count;

    assign o_full       = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Job storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    `U8D_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_push, !o_full)
    `U8D_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_pop, o_head_valid)

endmodule

// ----- sv/u8d_back.sv -----
// Back end: sends the results of each queued job one beat at a time.
`include "lenient_utf8_decoder_macros.svh"

module u8d_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  u8d_pkg::t_job i_head,
    output logic          o_pop,
    u8d_out_if.source     o_out
);
    import u8d_pkg::*;

    logic               r_valid;
    t_cp                r_cp;
    logic               r_last;
    logic [RES_IW-1:0]  r_idx;

    logic               load;
    logic               final_res;

    assign load      = i_head_valid && (!r_valid || o_out.ready);
    assign final_res = ((t_cnt'(r_idx) + t_cnt'(1)) == i_head.cnt);
    assign o_pop     = load && final_res;

    assign o_out.valid       = r_valid;
    assign o_out.code_point  = r_cp;
    assign o_out.last_of_run = r_last;

    // Output register control and position within the head job.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= final_res ? '0 : r_idx + 1'b1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_cp   <= i_head.cp[r_idx];
            r_last <= final_res;
        end
    end

    `U8D_ASSERT_IMP(a_partial_job_held, i_clk, i_rst_n, r_idx != '0, i_head_valid)

endmodule

// ----- sv/lenient_utf8_decoder.sv -----
// Top level of the lenient UTF-8 decoder with Windows-1252 fallback.
// Path: a result is written into the job queue when its byte is taken, then loaded into the output register.
// Throughput: one byte per cycle while each byte gives at most one code point and the
// receiver is ready; a byte that gives n results takes n output beats, absorbed by a 4-job queue.
// Reset: synchronous, active low; clears sequence state, queue and output valid.
module lenient_utf8_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    u8d_in_if.sink     i_in,
    u8d_out_if.source  o_out
);
    import u8d_pkg::*;

    logic   push;
    logic   pop;
    logic   q_full;
    logic   head_valid;
    t_job   job;
    t_job   head;

    u8d_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_job    (job)
    );

    u8d_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (job),
        .i_pop        (pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

// ----- sim/testbench.sv -----
// Testbench for the lenient UTF-8 decoder: directed and random byte streams against a predictor.
`timescale 1ns / 100ps

module testbench;
    import u8d_pkg::*;

    localparam int    HOLD_CYCLES = 80;
    localparam int    RAND_ITEMS  = 255;
    localparam int    DRAIN_WAIT  = 8;
    localparam time   RUN_LIMIT   = 2_000_000;

    // One expected output beat.
    typedef struct packed {
        t_cp  cp;
        logic last;
    } t_cp_beat;

    // Tracks decoder state and holds the code points still owed by the block.
    class cp_scoreboard;
        bit         seq_open;
        t_byte      lead;
        logic [1:0] need;
        logic [1:0] got;
        t_byte      held [3];
        t_cp_beat   owed_q [$];
        int         n_errors;

        function new();
            seq_open = 0;
            lead     = '0;
            need     = '0;
            got      = '0;
            n_errors = 0;
        endfunction

        // Windows-1252 characters for the stray bytes 0x80 to 0x9F.
        function t_cp win1252(t_byte b);
            t_cp v;
            case (b[4:0])
                5'h00: v = 21'h20AC;  5'h01: v = 21'h0081;
                5'h02: v = 21'h201A;  5'h03: v = 21'h0192;
                5'h04: v = 21'h201E;  5'h05: v = 21'h2026;
                5'h06: v = 21'h2020;  5'h07: v = 21'h2021;
                5'h08: v = 21'h02C6;  5'h09: v = 21'h2030;
                5'h0A: v = 21'h0160;  5'h0B: v = 21'h2039;
                5'h0C: v = 21'h0152;  5'h0D: v = 21'h008D;
                5'h0E: v = 21'h017D;  5'h0F: v = 21'h008F;
                5'h10: v = 21'h0090;  5'h11: v = 21'h2018;
                5'h12: v = 21'h2019;  5'h13: v = 21'h201C;
                5'h14: v = 21'h201D;  5'h15: v = 21'h2022;
                5'h16: v = 21'h2013;  5'h17: v = 21'h2014;
                5'h18: v = 21'h02DC;  5'h19: v = 21'h2122;
                5'h1A: v = 21'h0161;  5'h1B: v = 21'h203A;
                5'h1C: v = 21'h0153;  5'h1D: v = 21'h009D;
                5'h1E: v = 21'h017E;  default: v = 21'h0178;
            endcase
            return v;
        endfunction

        // A byte shown on its own.
        function t_cp lone_char(t_byte b);
            if (b >= CONT_LO && b < WIN_HI) begin
                return win1252(b);
            end
            return t_cp'(b);
        endfunction

        function void owe(t_cp v);
            t_cp_beat e;
            e.cp   = v;
            e.last = 1'b0;
            owed_q.push_back(e);
        endfunction

        function void drop_seq();
            seq_open = 0;
            lead     = '0;
            need     = '0;
            got      = '0;
        endfunction

        // A broken or cut-off sequence gives its start byte and then each held byte.
        function void flush_seq();
            int i;
            owe(t_cp'(lead));
            for (i = 0; i < got; i++) begin
                owe(lone_char(held[i]));
            end
            drop_seq();
        endfunction

        function t_cp assembled();
            t_cp v;
            case (need)
                2'd1:    v = t_cp'({lead[4:0], held[0][5:0]});
                2'd2:    v = t_cp'({lead[3:0], held[0][5:0], held[1][5:0]});
                default: v = t_cp'({lead[2:0], held[0][5:0], held[1][5:0], held[2][5:0]});
            endcase
            return v;
        endfunction

        // Works out the code points caused by one accepted input beat.
        function void note_beat(logic m, t_byte b);
            int first;
            bit fresh;
            first = owed_q.size();
            fresh = 1;
            if (m == MODE_EOS) begin
                if (seq_open) begin
                    flush_seq();
                end
                fresh = 0;
            end else if (seq_open) begin
                if (b >= CONT_LO && b < LEAD2_LO && got < need) begin
                    held[got] = b;
                    got       = got + 2'd1;
                    if (got == need) begin
                        owe(assembled());
                        drop_seq();
                    end
                    fresh = 0;
                end else begin
                    flush_seq();
                end
            end
            if (fresh) begin
                if (b >= LEAD2_LO && b < LATIN_LO) begin
                    seq_open = 1;
                    lead     = b;
                    need     = (b < LEAD3_LO) ? 2'd1 : (b < LEAD4_LO) ? 2'd2 : 2'd3;
                    got      = '0;
                end else begin
                    owe(lone_char(b));
                end
            end
            if (owed_q.size() > first) begin
                owed_q[owed_q.size() - 1].last = 1'b1;
            end
        endfunction

        // Compares one output beat with the oldest owed code point.
        function void check_cp(t_cp cp, logic last);
            t_cp_beat e;
            if (owed_q.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("%0t: unexpected code point %h last %b", $time, cp, last);
                end
                return;
            end
            e = owed_q.pop_front();
            if (e.cp !== cp || e.last !== last) begin
                n_errors++;
                if (n_errors <= 10) begin
                    $display("%0t: mismatch: expected cp %h last %b, got cp %h last %b",
                             $time, e.cp, e.last, cp, last);
                end
            end
        endfunction

        function int outstanding();
            return owed_q.size();
        endfunction

        function void close_out();
            if (owed_q.size() != 0) begin
                $display("%0d code points never arrived", owed_q.size());
                n_errors += owed_q.size();
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   no_idle;
    bit   hold_req;
    int   items_sent;

    cp_scoreboard sb;

    u8d_in_if  in_bus ();
    u8d_out_if out_bus ();

    lenient_utf8_decoder u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    // Clock.
    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(RUN_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    // Predict from every accepted input beat.
    always @(posedge clk) begin
        if (rst_n && in_bus.valid && in_bus.ready) begin
            sb.note_beat(in_bus.mode, in_bus.data_byte);
        end
    end

    // Check every accepted output beat.
    always @(posedge clk) begin
        if (rst_n && out_bus.valid && out_bus.ready) begin
            sb.check_cp(out_bus.code_point, out_bus.last_of_run);
        end
    end

    // Receiver: random stalls per beat, plus one long hold-off on request.
    initial begin
        int stall;
        out_bus.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                out_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 0;
            end
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                out_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge clk);
            while (!out_bus.valid) @(posedge clk);
        end
    end

    // Offers one beat after a random gap (none in back-to-back mode) and waits until it is taken.
    task automatic send_item(input logic m, input t_byte b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_bus.valid     <= 1'b1;
        in_bus.mode      <= m;
        in_bus.data_byte <= b;
        @(posedge clk);
        while (!in_bus.ready) @(posedge clk);
        items_sent++;
    endtask

    function automatic t_byte rand_cont();
        return t_byte'($urandom_range(8'h80, 8'hBF));
    endfunction

    function automatic t_byte rand_lead(int n_cont);
        case (n_cont)
            1:       return t_byte'($urandom_range(8'hC0, 8'hDF));
            2:       return t_byte'($urandom_range(8'hE0, 8'hEF));
            default: return t_byte'($urandom_range(8'hF0, 8'hF7));
        endcase
    endfunction

    // One random unit of stream: mostly well-formed text, some broken runs and noise.
    task automatic send_random_unit();
        int    pick;
        int    len;
        int    k;
        int    i;
        t_byte b;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
            send_item(MODE_DATA, t_byte'($urandom_range(0, 127)));
        end else if (pick < 64) begin
            len = (pick < 40) ? 1 : (pick < 52) ? 2 : 3;
            send_item(MODE_DATA, rand_lead(len));
            for (i = 0; i < len; i++) begin
                send_item(MODE_DATA, rand_cont());
            end
        end else if (pick < 72) begin
            if ($urandom_range(0, 3) == 0) begin
                b = t_byte'($urandom_range(8'hF8, 8'hFF));
            end else begin
                b = rand_cont();
            end
            send_item(MODE_DATA, b);
        end else if (pick < 88) begin
            // Sequence cut short by a foreign byte or by end of stream.
            len = $urandom_range(1, 3);
            k   = $urandom_range(0, len - 1);
            send_item(MODE_DATA, rand_lead(len));
            for (i = 0; i < k; i++) begin
                send_item(MODE_DATA, rand_cont());
            end
            if (pick < 82) begin
                b = t_byte'($urandom);
                if (b >= CONT_LO && b < LEAD2_LO) begin
                    b[6] = 1'b1;
                end
                send_item(MODE_DATA, b);
            end else begin
                send_item(MODE_EOS, t_byte'($urandom));
            end
        end else if (pick < 93) begin
            send_item(MODE_EOS, t_byte'($urandom));
        end else begin
            send_item(MODE_DATA, t_byte'($urandom));
        end
    endtask

    // Main sequence: reset, directed stream, three random phases, drain.
    initial begin
        logic [8:0] directed_q [$];
        int         target;
        int         i;
        directed_q = '{
            // Single bytes at the edges of each class.
            {MODE_DATA, 8'h00}, {MODE_DATA, 8'h80}, {MODE_DATA, 8'h9F},
            {MODE_DATA, 8'hA0}, {MODE_DATA, 8'hF8}, {MODE_DATA, 8'hFF},
            // Largest two-byte and four-byte values, and a three-byte euro sign.
            {MODE_DATA, 8'hDF}, {MODE_DATA, 8'hBF},
            {MODE_DATA, 8'hE2}, {MODE_DATA, 8'h82}, {MODE_DATA, 8'hAC},
            {MODE_DATA, 8'hF7}, {MODE_DATA, 8'hBF}, {MODE_DATA, 8'hBF}, {MODE_DATA, 8'hBF},
            // Broken sequence with two held bytes: four results from one byte.
            {MODE_DATA, 8'hF0}, {MODE_DATA, 8'h9F}, {MODE_DATA, 8'h98}, {MODE_DATA, 8'h41},
            // End of stream with a held byte pending.
            {MODE_DATA, 8'hE2}, {MODE_DATA, 8'h82}, {MODE_EOS, 8'hFF},
            // A start byte that meets another start byte, then end of stream with the second one pending.
            {MODE_DATA, 8'hC3}, {MODE_DATA, 8'hF0}, {MODE_EOS, 8'h00},
            // End of stream with nothing pending.
            {MODE_EOS, 8'h00}
        };
        sb         = new();
        no_idle    = 0;
        hold_req   = 0;
        items_sent = 0;

        in_bus.valid     <= 1'b0;
        in_bus.mode      <= MODE_DATA;
        in_bus.data_byte <= '0;
        rst_n            <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (i = 0; i < directed_q.size(); i++) begin
            send_item(directed_q[i][8], directed_q[i][7:0]);
        end

        // Random phase with idling on both sides.
        target = items_sent + RAND_ITEMS / 3;
        while (items_sent < target) send_random_unit();

        // Back-to-back phase with the receiver holding off, so the block stalls its input.
        no_idle  = 1;
        hold_req = 1;
        target   = items_sent + RAND_ITEMS / 3;
        while (items_sent < target) send_random_unit();
        no_idle = 0;

        // Random phase with idling again, ending on a flush.
        target = items_sent + RAND_ITEMS / 3;
        while (items_sent < target) send_random_unit();
        send_item(MODE_EOS, t_byte'($urandom));
        in_bus.valid <= 1'b0;

        while (sb.outstanding() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        sb.close_out();

        if (sb.n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+sv
sv/u8d_pkg.sv
sv/u8d_if.sv
sv/u8d_front.sv
sv/u8d_queue.sv
sv/u8d_back.sv
sv/lenient_utf8_decoder.sv
sim/testbench.sv
